/* sv/dmm_pkg.sv */
// dmm_pkg: shared sizes, codes, state type and control structs for the
// dense matrix multiply unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dmm_pkg;

  // store geometry
  localparam int MAX_DIM = 16;
  localparam int DIM_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = $clog2(DEPTH);

  // row/column count in use never exceeds this
  localparam int EFF_MAX = (MAX_DIM < 16) ? MAX_DIM : 16;
  localparam int SIZE_W  = 5;
  localparam int CMP_W   = (DIM_W > SIZE_W) ? DIM_W : SIZE_W;

  // fixed-point datapath
  localparam int DATA_W = 32;
  localparam int PROD_W = 2 * DATA_W;
  localparam int FRAC_W = 16;
  localparam int ACC_W  = PROD_W + $clog2(EFF_MAX) + 1;
  localparam int COL_W  = 4;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

  // func codes
  localparam logic [1:0] FUNC_LOAD_A  = 2'd0;
  localparam logic [1:0] FUNC_LOAD_B  = 2'd1;
  localparam logic [1:0] FUNC_COMPUTE = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_t;

  // tags that travel with each multiply-accumulate step
  typedef struct packed {
    logic             v;
    logic             first;
    logic             lastk;
    logic             lastj;
    logic [COL_W-1:0] col;
  } mac_ctl_t;

  // finished C element waiting for the output register
  typedef struct packed {
    logic                     v;
    logic [COL_W-1:0]         col;
    logic                     last;
    logic signed [DATA_W-1:0] product;
    logic                     overflow;
  } mac_res_t;

  // active size clamped to 1..EFF_MAX
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    r = s;
    if (s == '0) r = SIZE_W'(1);
    else if (int'(s) > EFF_MAX) r = SIZE_W'(EFF_MAX);
    return r;
  endfunction

endpackage
`default_nettype wire

/* sv/dmm_store.sv */
// dmm_store: one matrix store, one write port and one registered read port.
// Depends on dmm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dmm_store (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [dmm_pkg::ADDR_W-1:0] waddr,
  input  wire logic [dmm_pkg::DATA_W-1:0] wdata,
  input  wire logic                       re,
  input  wire logic [dmm_pkg::ADDR_W-1:0] raddr,
  output logic      [dmm_pkg::DATA_W-1:0] rdata
);
  import dmm_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while the pipeline is held
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* sv/dmm_seq.sv */
// dmm_seq: transaction decode, store writes and the row/column/k sequencer
// that issues one MAC step per cycle when adv is high. Depends on dmm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dmm_seq (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 in_func,
  input  wire logic [3:0]                 in_row,
  input  wire logic [3:0]                 in_col,
  input  wire logic [dmm_pkg::SIZE_W-1:0] size_cfg,
  input  wire logic                       adv,
  output logic                            a_we,
  output logic                            b_we,
  output logic      [dmm_pkg::ADDR_W-1:0] waddr,
  output logic      [dmm_pkg::ADDR_W-1:0] a_raddr,
  output logic      [dmm_pkg::ADDR_W-1:0] b_raddr,
  output dmm_pkg::mac_ctl_t               issue
);
  import dmm_pkg::*;

  seq_state_t        state_r, state_nxt;
  logic [3:0]        row_r, row_nxt;
  logic [SIZE_W-1:0] last_r, last_nxt;
  logic [DIM_W-1:0]  j_r, j_nxt;
  logic [DIM_W-1:0]  k_r, k_nxt;
  logic [SIZE_W-1:0] eff;
  logic              accept;
  logic              load_ok;
  logic              start;
  logic              k_last;
  logic              j_last;

  assign eff     = eff_size(size_cfg);
  assign accept  = in_valid && !in_stall;
  assign load_ok = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
  assign start   = accept && (in_func == FUNC_COMPUTE) && ({1'b0, in_row} < eff);
  assign k_last  = CMP_W'(k_r) == CMP_W'(last_r);
  assign j_last  = CMP_W'(j_r) == CMP_W'(last_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start) state_nxt = ST_RUN;
      ST_RUN:  if (adv && k_last && j_last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // counters and latched row
  always_comb begin
    row_nxt  = row_r;
    last_nxt = last_r;
    j_nxt    = j_r;
    k_nxt    = k_r;
    if (start) begin
      row_nxt  = in_row;
      last_nxt = eff - SIZE_W'(1);
      j_nxt    = '0;
      k_nxt    = '0;
    end else if (state_r == ST_RUN && adv) begin
      if (k_last) begin
        k_nxt = '0;
        j_nxt = j_r + DIM_W'(1);
      end else begin
        k_nxt = k_r + DIM_W'(1);
      end
    end
  end

  // outputs
  always_comb begin
    in_stall    = (state_r != ST_IDLE);
    a_we        = accept && (in_func == FUNC_LOAD_A) && load_ok;
    b_we        = accept && (in_func == FUNC_LOAD_B) && load_ok;
    waddr       = ADDR_W'(ADDR_W'(in_row) * ADDR_W'(MAX_DIM) + ADDR_W'(in_col));
    a_raddr     = ADDR_W'(ADDR_W'(row_r) * ADDR_W'(MAX_DIM) + ADDR_W'(k_r));
    b_raddr     = ADDR_W'(ADDR_W'(k_r) * ADDR_W'(MAX_DIM) + ADDR_W'(j_r));
    issue.v     = (state_r == ST_RUN);
    issue.first = (k_r == '0);
    issue.lastk = k_last;
    issue.lastj = j_last;
    issue.col   = COL_W'(j_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r  <= row_nxt;
    last_r <= last_nxt;
    j_r    <= j_nxt;
    k_r    <= k_nxt;
  end

endmodule
`default_nettype wire

/* sv/dmm_mac.sv */
// dmm_mac: shared 32x32 multiplier, wide accumulator and Q16.16 rounding
// with saturation. Depends on dmm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dmm_mac (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              adv,
  input  wire dmm_pkg::mac_ctl_t                 ctl_in,
  input  wire logic signed [dmm_pkg::DATA_W-1:0] a_in,
  input  wire logic signed [dmm_pkg::DATA_W-1:0] b_in,
  output dmm_pkg::mac_res_t                      res
);
  import dmm_pkg::*;

  mac_ctl_t                  ctl2_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   shifted;
  logic                      fin_v_r;
  logic [COL_W-1:0]          fin_col_r;
  logic                      fin_last_r;
  logic                      in_range;

  // multiply stage
  assign prod_nxt = a_in * b_in;

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
    end else if (adv) begin
      ctl2_r <= ctl_in;
    end
  end

  // accumulate stage, restarted on the first k of each column
  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_comb begin
    acc_nxt = acc_r;
    if (ctl2_r.v) begin
      acc_nxt = ctl2_r.first ? prod_ext : acc_r + prod_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      acc_r      <= acc_nxt;
      fin_col_r  <= ctl2_r.col;
      fin_last_r <= ctl2_r.lastj;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (adv) begin
      fin_v_r <= ctl2_r.v && ctl2_r.lastk;
    end
  end

  // floor shift, then saturate to 32 bits
  assign shifted  = acc_r >>> FRAC_W;
  assign in_range = (&shifted[ACC_W-1:DATA_W-1]) || !(|shifted[ACC_W-1:DATA_W-1]);

  always_comb begin
    res.v    = fin_v_r;
    res.col  = fin_col_r;
    res.last = fin_last_r;
    if (in_range) begin
      res.product  = shifted[DATA_W-1:0];
      res.overflow = 1'b0;
    end else begin
      res.product  = acc_r[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      res.overflow = 1'b1;
    end
  end

endmodule
`default_nettype wire

/* sv/dense_matrix_multiply_unit.sv */
// Dense matrix multiply unit, C = A x B over signed Q16.16 elements.
// Loads, func 3 and computes on rows past the size do not stall the input. A
// compute on a row in range holds the input until the row is done, issuing one
// multiply-accumulate a cycle on the one shared MAC while no stalled result holds it;
// each C element passes the store read, multiply, accumulate and output registers.
// Synchronous active-low reset clears control state and sets size to 16; stores kept.
`timescale 1ns / 1ps
`default_nettype none
module dense_matrix_multiply_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 in_func,
  input  wire logic [3:0]                 in_row,
  input  wire logic [3:0]                 in_col,
  input  wire logic signed [31:0]         in_element,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [3:0]                      out_result_col,
  output logic signed [31:0]              out_product,
  output logic                            out_overflow,
  output logic                            out_last,
  input  wire logic                       cfg_we,
  input  wire logic [dmm_pkg::SIZE_W-1:0] cfg_wdata
);
  import dmm_pkg::*;

  logic [SIZE_W-1:0] size_r;
  logic              adv;
  logic              a_we, b_we;
  logic [ADDR_W-1:0] waddr, a_raddr, b_raddr;
  logic [DATA_W-1:0] a_rdata, b_rdata;
  mac_ctl_t          issue;
  mac_ctl_t          ctl1_r;
  mac_res_t          res;

  logic              out_valid_r, out_valid_nxt;
  logic [COL_W-1:0]  col_r;
  logic [DATA_W-1:0] prod_r;
  logic              ovf_r;
  logic              last_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (cfg_we) begin
      size_r <= cfg_wdata;
    end
  end

  // whole pipeline holds while a finished element cannot enter the output
  assign adv = !(res.v && out_valid_r && out_stall);

  dmm_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_func  (in_func),
    .in_row   (in_row),
    .in_col   (in_col),
    .size_cfg (size_r),
    .adv      (adv),
    .a_we     (a_we),
    .b_we     (b_we),
    .waddr    (waddr),
    .a_raddr  (a_raddr),
    .b_raddr  (b_raddr),
    .issue    (issue)
  );

  dmm_store u_store_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (waddr),
    .wdata (in_element),
    .re    (adv),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  dmm_store u_store_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (waddr),
    .wdata (in_element),
    .re    (adv),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // tags aligned with the store read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else if (adv) begin
      ctl1_r <= issue;
    end
  end

  dmm_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .ctl_in (ctl1_r),
    .a_in   (signed'(a_rdata)),
    .b_in   (signed'(b_rdata)),
    .res    (res)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.v && adv) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.v && adv) begin
      col_r  <= res.col;
      prod_r <= res.product;
      ovf_r  <= res.overflow;
      last_r <= res.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_result_col = col_r;
  assign out_product    = signed'(prod_r);
  assign out_overflow   = ovf_r;
  assign out_last       = last_r;

  // a compute transaction on a row in range takes over the input
  a_compute_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_func == FUNC_COMPUTE && {1'b0, in_row} < eff_size(size_r)
    |=> in_stall)
    else $error("compute transaction did not start the sequencer");

  // overflow only ever comes with a saturated value
  a_ovf_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow
    |-> out_product == 32'sh7FFFFFFF || out_product == -32'sh80000000)
    else $error("overflow flag without saturated product");

  // a blocked finished element is kept until the output frees up
  a_fin_held: assert property (@(posedge clk) disable iff (!rst_n)
    res.v && out_valid_r && out_stall
    |=> res.v && $stable(res.product) && $stable(res.col))
    else $error("finished element lost while output stalled");

endmodule
`default_nettype wire
